/* sv/wsdb_pkg.sv */
// ----------------------------------------------------------------------------
// wsdb_pkg
// Shared types and codes of the work-stealing deque bank: operation and
// status codes, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdb_pkg;

	// Default sizes
	localparam int unsigned NUM_QUEUES_DEF  = 4;
	localparam int unsigned RING_SLOTS_DEF  = 16;
	localparam int unsigned HANDLE_BITS_DEF = 32;

	// Operation codes
	localparam logic [1:0] KIND_PUSH  = 2'd0;
	localparam logic [1:0] KIND_POP   = 2'd1;
	localparam logic [1:0] KIND_STEAL = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Sequencer states
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDQ  = 5'b00010,
		S_EXEC = 5'b00100,
		S_WRT  = 5'b01000,
		S_OUT  = 5'b10000
	} wsdb_state_t;

	// Fold a 2-bit queue number into the range of n queues
	function automatic logic [1:0] fold_queue(input logic [1:0] v, input int unsigned n);
		logic [1:0] r;
		r = v;
		for (int i = 0; i < 3; i++) begin
			if ({30'b0, r} >= n) begin
				r = r - n[1:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/wsdb_task_ram.sv */
// ----------------------------------------------------------------------------
// wsdb_task_ram
// Task handle ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdb_task_ram #(
	parameter int unsigned DEPTH = wsdb_pkg::NUM_QUEUES_DEF * wsdb_pkg::RING_SLOTS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned DW    = wsdb_pkg::HANDLE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/work_stealing_deque_bank.sv */
// ----------------------------------------------------------------------------
// work_stealing_deque_bank
// Bank of circular work-stealing deques holding task handles.
//
// The input channel (in_valid/in_stall) carries one operation per
// transaction: push a handle at the top of queue_id, pop the newest handle
// from the top, or steal the oldest handle from the bottom of queue_id and
// push it onto thief_id. Each operation yields exactly one result
// transaction on the output channel (out_valid/out_stall) with status and
// the handle taken (zero unless the operation removed a handle).
// Operations run one at a time through a sequencer around two memories
// with registered reads (queue pointers and handle rings): read pointers,
// read the ring, update, write back; a steal between two different queues
// writes the thief's pointers back in a further state. The next operation
// is taken the cycle after its result is loaded, not before.
// A result waits in the output register while out_stall is high; the block
// holds the next item's completion until that register is free.
// Reset clears all pointers at once (per-queue valid bits); ring contents
// are undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_deque_bank #(
	parameter int unsigned NUM_QUEUES  = wsdb_pkg::NUM_QUEUES_DEF,
	parameter int unsigned RING_SLOTS  = wsdb_pkg::RING_SLOTS_DEF,
	parameter int unsigned HANDLE_BITS = wsdb_pkg::HANDLE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [1:0]  queue_id,
	input  wire logic [1:0]  thief_id,
	input  wire logic [31:0] task_handle,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      task_out
);

	localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int unsigned PW    = $clog2(RING_SLOTS);
	localparam int unsigned DEPTH = NUM_QUEUES * RING_SLOTS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned EW    = 2 * PW;

	// Ring pointer helpers
	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(RING_SLOTS - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
		return (p == '0) ? PW'(RING_SLOTS - 1) : p - PW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q, input logic [PW-1:0] p);
		return AW'(q) * AW'(RING_SLOTS) + AW'(p);
	endfunction

	wsdb_pkg::wsdb_state_t state_q, state_d;

	logic             in_acc;
	logic [QW-1:0]    in_q;

	logic [1:0]       kind_q;
	logic [QW-1:0]    q_q;
	logic [QW-1:0]    th_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// Pointer memory: entry = {top, bottom}
	logic [EW-1:0]    ptr_mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] ptr_vld_q;
	logic             ptr_re;
	logic [QW-1:0]    ptr_raddr;
	logic [EW-1:0]    ptr_rd_q;
	logic             ptr_rd_vld_q;
	logic [EW-1:0]    ptr_rd;
	logic             ptr_we;
	logic [QW-1:0]    ptr_waddr;
	logic [EW-1:0]    ptr_wdata;

	logic [PW-1:0]    qtop_q, qbot_q;
	logic [EW-1:0]    th_entry_q;

	// Task ring port signals
	logic             st_re;
	logic [AW-1:0]    st_raddr;
	logic [HANDLE_BITS-1:0] st_rdata;
	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [HANDLE_BITS-1:0] st_wdata;

	// Execute stage decisions
	logic [PW-1:0]    t_top, t_bot;
	logic             q_empty, q_full, t_full, same_q;
	logic             ex_ptr_we;
	logic [EW-1:0]    ex_ptr_wdata;
	logic             ex_st_we;
	logic [AW-1:0]    ex_st_waddr;
	logic [HANDLE_BITS-1:0] ex_st_wdata;
	logic             ex_go_wrt;
	logic [EW-1:0]    ex_th_entry;
	logic [1:0]       ex_status;
	logic [31:0]      ex_task;
	logic [1:0]       res_status_q;
	logic [31:0]      res_task_q;

	assign in_stall = (state_q != wsdb_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign in_q     = QW'(wsdb_pkg::fold_queue(queue_id, NUM_QUEUES));

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= kind;
			q_q      <= in_q;
			th_q     <= QW'(wsdb_pkg::fold_queue(thief_id, NUM_QUEUES));
			handle_q <= HANDLE_BITS'(task_handle);
		end
	end

	// Pointer memory ports
	assign ptr_re    = in_acc || (state_q == wsdb_pkg::S_RDQ);
	assign ptr_raddr = (state_q == wsdb_pkg::S_IDLE) ? in_q : th_q;
	assign ptr_we    = ((state_q == wsdb_pkg::S_EXEC) && ex_ptr_we) ||
	                   (state_q == wsdb_pkg::S_WRT);
	assign ptr_waddr = (state_q == wsdb_pkg::S_WRT) ? th_q : q_q;
	assign ptr_wdata = (state_q == wsdb_pkg::S_WRT) ? th_entry_q : ex_ptr_wdata;
	assign ptr_rd    = ptr_rd_vld_q ? ptr_rd_q : '0;

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_waddr] <= ptr_wdata;
		end
		if (ptr_re) begin
			ptr_rd_q <= ptr_mem[ptr_raddr];
		end
	end

	// Track written pointer entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q    <= '0;
			ptr_rd_vld_q <= 1'b0;
		end else begin
			if (ptr_we) begin
				ptr_vld_q[ptr_waddr] <= 1'b1;
			end
			if (ptr_re) begin
				ptr_rd_vld_q <= ptr_vld_q[ptr_raddr];
			end
		end
	end

	// Hold the source queue pointers once read
	always_ff @(posedge clk) begin
		if (state_q == wsdb_pkg::S_RDQ) begin
			qtop_q <= ptr_rd[EW-1:PW];
			qbot_q <= ptr_rd[PW-1:0];
		end
	end

	// Issue the ring read from the fresh source pointers
	assign st_re    = (state_q == wsdb_pkg::S_RDQ);
	assign st_raddr = (kind_q == wsdb_pkg::KIND_STEAL) ? slot_addr(q_q, ptr_rd[PW-1:0])
	                                                   : slot_addr(q_q, ring_prev(ptr_rd[EW-1:PW]));
	assign st_we    = (state_q == wsdb_pkg::S_EXEC) && ex_st_we;
	assign st_waddr = ex_st_waddr;
	assign st_wdata = ex_st_wdata;

	wsdb_task_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (HANDLE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Decide the operation outcome and the write-backs
	always_comb begin
		same_q  = (th_q == q_q);
		t_top   = same_q ? qtop_q : ptr_rd[EW-1:PW];
		t_bot   = same_q ? qbot_q : ptr_rd[PW-1:0];
		q_empty = (qtop_q == qbot_q);
		q_full  = (ring_next(qtop_q) == qbot_q);
		t_full  = (ring_next(t_top) == t_bot);

		ex_ptr_we    = 1'b0;
		ex_ptr_wdata = {qtop_q, qbot_q};
		ex_st_we     = 1'b0;
		ex_st_waddr  = slot_addr(q_q, qtop_q);
		ex_st_wdata  = handle_q;
		ex_go_wrt    = 1'b0;
		ex_th_entry  = {ring_next(t_top), t_bot};
		ex_status    = wsdb_pkg::STATUS_OK;
		ex_task      = '0;

		unique case (kind_q)
			wsdb_pkg::KIND_PUSH: begin
				if (q_full) begin
					ex_status = wsdb_pkg::STATUS_FULL;
				end else begin
					ex_st_we     = 1'b1;
					ex_ptr_we    = 1'b1;
					ex_ptr_wdata = {ring_next(qtop_q), qbot_q};
				end
			end
			wsdb_pkg::KIND_POP: begin
				if (q_empty) begin
					ex_status = wsdb_pkg::STATUS_EMPTY;
				end else begin
					ex_ptr_we    = 1'b1;
					ex_ptr_wdata = {ring_prev(qtop_q), qbot_q};
					ex_task      = 32'(st_rdata);
				end
			end
			wsdb_pkg::KIND_STEAL: begin
				if (q_empty) begin
					ex_status = wsdb_pkg::STATUS_EMPTY;
				end else if (!same_q && t_full) begin
					ex_status = wsdb_pkg::STATUS_FULL;
				end else begin
					ex_task     = 32'(st_rdata);
					ex_st_wdata = st_rdata;
					ex_st_we    = 1'b1;
					ex_ptr_we   = 1'b1;
					if (same_q) begin
						ex_ptr_wdata = {ring_next(qtop_q), ring_next(qbot_q)};
					end else begin
						ex_ptr_wdata = {qtop_q, ring_next(qbot_q)};
						ex_st_waddr  = slot_addr(th_q, t_top);
						ex_go_wrt    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the result and the thief pointer update
	always_ff @(posedge clk) begin
		if (state_q == wsdb_pkg::S_EXEC) begin
			res_status_q <= ex_status;
			res_task_q   <= ex_task;
			th_entry_q   <= ex_th_entry;
		end
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wsdb_pkg::S_IDLE: if (in_acc) state_d = wsdb_pkg::S_RDQ;
			wsdb_pkg::S_RDQ:  state_d = wsdb_pkg::S_EXEC;
			wsdb_pkg::S_EXEC: state_d = ex_go_wrt ? wsdb_pkg::S_WRT : wsdb_pkg::S_OUT;
			wsdb_pkg::S_WRT:  state_d = wsdb_pkg::S_OUT;
			wsdb_pkg::S_OUT:  if (!out_valid || !out_stall) state_d = wsdb_pkg::S_IDLE;
			default:          state_d = wsdb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsdb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register: load when free, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == wsdb_pkg::S_OUT) && (!out_valid || !out_stall)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == wsdb_pkg::S_OUT) && (!out_valid || !out_stall)) begin
			status   <= res_status_q;
			task_out <= res_task_q;
		end
	end

	// Pointer write-backs come only from the update states
	assert property (@(posedge clk) disable iff (!arst_n)
		ptr_we |-> (state_q == wsdb_pkg::S_EXEC || state_q == wsdb_pkg::S_WRT))
		else $error("pointer write outside update states");

	// The thief write-back belongs to a steal between two queues
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsdb_pkg::S_WRT) |-> (kind_q == wsdb_pkg::KIND_STEAL && th_q != q_q))
		else $error("thief update without cross-queue steal");

	// A new result is loaded only from the result state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == wsdb_pkg::S_OUT))
		else $error("result appeared outside result state");

	// A failed operation returns no handle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != wsdb_pkg::STATUS_OK) |-> (task_out == 32'd0))
		else $error("handle returned with failure status");

	// No new transaction is accepted in the pointer read state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsdb_pkg::S_RDQ) |-> in_stall)
		else $error("input accepted during operation");

endmodule

`default_nettype wire

/* test/work_stealing_deque_bank_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_stealing_deque_bank_tb
// Self-checking bench for the deque bank. Directed tests cover empty queues,
// the unused operation, a ring filled to capacity, steals into a full queue
// and a steal of a queue onto itself. A long random mix of push, pop and
// steal follows, with the mix shifting between fill and drain phases. A
// bench-side copy of the rings predicts every result. The sender idles in
// random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module work_stealing_deque_bank_tb;

	localparam int unsigned NQ           = wsdb_pkg::NUM_QUEUES_DEF;
	localparam int unsigned RS           = wsdb_pkg::RING_SLOTS_DEF;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;
	localparam int unsigned RANDOM_OPS   = 750;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// random mix phases
	localparam int unsigned MIX_FILL     = 0;
	localparam int unsigned MIX_DRAIN    = 1;
	localparam int unsigned MIX_BALANCED = 2;

	// receiver stall patterns
	localparam int unsigned STALL_NONE     = 0;
	localparam int unsigned STALL_RANDOM   = 1;
	localparam int unsigned STALL_PERIODIC = 2;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle;
	} op_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  kind        = '0;
	logic [1:0]  queue_id    = '0;
	logic [1:0]  thief_id    = '0;
	logic [31:0] task_handle = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  status;
	logic [31:0] task_out;

	work_stealing_deque_bank DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.queue_id    (queue_id),
		.thief_id    (thief_id),
		.task_handle (task_handle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.task_out    (task_out)
	);

	always #10 clk = ~clk;

	// Bench copy of the rings
	logic [31:0] handle_ring [NQ*RS];
	int unsigned top_slot    [NQ];
	int unsigned bottom_slot [NQ];

	op_result_t  pending_results [$];
	op_result_t  oldest_result;

	int unsigned error_count   = 0;
	int unsigned checked_count = 0;
	int unsigned cycle_count   = 0;
	int unsigned burst_left    = 0;
	int unsigned stall_mode    = STALL_NONE;
	int unsigned stall_left    = 0;
	int unsigned stall_phase   = 0;
	int unsigned n_push = 0, n_pop = 0, n_steal = 0;
	int unsigned n_empty = 0, n_full = 0, n_self = 0, n_unused = 0;

	function automatic bit deque_empty(int unsigned q);
		return top_slot[q] == bottom_slot[q];
	endfunction

	function automatic bit deque_full(int unsigned q);
		return ((top_slot[q] + 1) % RS) == bottom_slot[q];
	endfunction

	function automatic void place_on_top(int unsigned q, logic [31:0] h);
		handle_ring[q*RS + top_slot[q]] = h;
		top_slot[q] = (top_slot[q] + 1) % RS;
	endfunction

	// Apply one operation to the bench rings and return its result
	function automatic op_result_t apply_op(logic [1:0] op, logic [1:0] qid,
			logic [1:0] tid, logic [31:0] h);
		int unsigned q;
		int unsigned th;
		op_result_t  r;
		q = qid % NQ;
		th = tid % NQ;
		r.status = wsdb_pkg::STATUS_OK;
		r.handle = '0;
		case (op)
			wsdb_pkg::KIND_PUSH: begin
				if (deque_full(q)) begin
					r.status = wsdb_pkg::STATUS_FULL;
					n_full++;
				end else begin
					place_on_top(q, h);
					n_push++;
				end
			end
			wsdb_pkg::KIND_POP: begin
				if (deque_empty(q)) begin
					r.status = wsdb_pkg::STATUS_EMPTY;
					n_empty++;
				end else begin
					top_slot[q] = (top_slot[q] + RS - 1) % RS;
					r.handle = handle_ring[q*RS + top_slot[q]];
					n_pop++;
				end
			end
			wsdb_pkg::KIND_STEAL: begin
				if (deque_empty(q)) begin
					r.status = wsdb_pkg::STATUS_EMPTY;
					n_empty++;
				end else if (th != q && deque_full(th)) begin
					r.status = wsdb_pkg::STATUS_FULL;
					n_full++;
				end else begin
					// take the oldest first: a self steal frees its slot before the push
					r.handle = handle_ring[q*RS + bottom_slot[q]];
					bottom_slot[q] = (bottom_slot[q] + 1) % RS;
					place_on_top(th, r.handle);
					n_steal++;
					if (th == q) begin
						n_self++;
					end
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		return r;
	endfunction

	// Send one transaction, idling between random-length bursts
	task automatic send_op(input logic [1:0] op, input logic [1:0] qid,
			input logic [1:0] tid, input logic [31:0] h);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		kind        <= op;
		queue_id    <= qid;
		thief_id    <= tid;
		task_handle <= h;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pending_results.push_back(apply_op(op, qid, tid, h));
	endtask

	// Pop and steal on empty queues, and the unused operation
	task automatic test_empty_ops();
		send_op(wsdb_pkg::KIND_POP, 2'd0, 2'd3, $urandom());
		send_op(wsdb_pkg::KIND_STEAL, 2'd1, 2'd2, $urandom());
		send_op(KIND_UNUSED, 2'd2, 2'd1, $urandom());
	endtask

	// Fill one ring, then hit full on push and steal, and steal onto itself
	task automatic test_full_ring();
		send_op(wsdb_pkg::KIND_PUSH, 2'd3, 2'd0, 32'h0000_0000);
		send_op(wsdb_pkg::KIND_PUSH, 2'd3, 2'd1, 32'hFFFF_FFFF);
		repeat (RS - 3) send_op(wsdb_pkg::KIND_PUSH, 2'd3, 2'($urandom()), $urandom());
		send_op(wsdb_pkg::KIND_PUSH, 2'd3, 2'd2, $urandom());
		send_op(wsdb_pkg::KIND_PUSH, 2'd0, 2'd3, $urandom());
		send_op(wsdb_pkg::KIND_STEAL, 2'd0, 2'd3, $urandom());
		send_op(wsdb_pkg::KIND_STEAL, 2'd3, 2'd3, $urandom());
		send_op(wsdb_pkg::KIND_POP, 2'd3, 2'd0, $urandom());
		send_op(wsdb_pkg::KIND_STEAL, 2'd3, 2'd0, $urandom());
	endtask

	// Random mix that shifts between filling and draining the bank
	task automatic test_random_mix();
		int unsigned counted;
		int unsigned mix;
		int unsigned mix_left;
		int unsigned roll;
		logic [1:0]  op;
		counted = 0;
		mix = MIX_BALANCED;
		mix_left = 0;
		while (counted < RANDOM_OPS) begin
			if (mix_left == 0) begin
				mix = $urandom_range(MIX_FILL, MIX_BALANCED);
				mix_left = $urandom_range(20, 80);
			end
			mix_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				op = KIND_UNUSED;
			end else begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:  op = (roll < 70) ? wsdb_pkg::KIND_PUSH :
					                (roll < 85) ? wsdb_pkg::KIND_POP : wsdb_pkg::KIND_STEAL;
					MIX_DRAIN: op = (roll < 25) ? wsdb_pkg::KIND_PUSH :
					                (roll < 60) ? wsdb_pkg::KIND_POP : wsdb_pkg::KIND_STEAL;
					default:   op = (roll < 45) ? wsdb_pkg::KIND_PUSH :
					                (roll < 72) ? wsdb_pkg::KIND_POP : wsdb_pkg::KIND_STEAL;
				endcase
			end
			send_op(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom());
			if (op != KIND_UNUSED) begin
				counted++;
			end
		end
	endtask

	// Check each result transaction and advance the stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d task_out %h",
					$time, status, task_out);
				error_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				checked_count++;
				if (status !== oldest_result.status) begin
					$display("%0t: status expected %0d, actual %0d",
						$time, oldest_result.status, status);
					error_count++;
				end
				if (task_out !== oldest_result.handle) begin
					$display("%0t: task_out expected %h, actual %h",
						$time, oldest_result.handle, task_out);
					error_count++;
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
			STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
			default:        out_stall <= 1'b0;
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("work_stealing_deque_bank_tb: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ops();
		test_full_ring();
		test_random_mix();

		// drain outstanding results, then let the pipeline settle
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d push, %0d pop, %0d steal (%0d onto itself) ok,",
			checked_count, n_push, n_pop, n_steal, n_self);
		$display("%0d empty, %0d full, %0d unused ops; %0d mismatches",
			n_empty, n_full, n_unused, error_count);
		if (error_count == 0) begin
			$display("work_stealing_deque_bank_tb: done, clean");
		end else begin
			$display("work_stealing_deque_bank_tb: done, errors");
		end
		$finish;
	end

endmodule
